@@ rtl/core/ibci_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibci_pkg
// Shared constants and types for the IMU bias calibration and angle
// integration core.
// ----------------------------------------------------------------------------
package ibci_pkg;

    localparam int CAL_SAMPLES = 1000;

    localparam int SMP_W   = 16;
    localparam int GRAV_W  = 15;
    localparam int DT_W    = 16;
    localparam int CNT_W   = 10;
    localparam int SUM_W   = 32;
    localparam int ANG_W   = 48;
    localparam int PROD_W  = SMP_W + DT_W + 1;
    localparam int DCNT_W  = 2;

    // |sum| <= CAL_SAMPLES * 65535 < 2^MAG_W; with the rounded-up reciprocal
    // the error term stays below 2^RECIP_SH, so the quotient is exact
    localparam int MAG_W    = 27;
    localparam int RECIP_SH = MAG_W + 10;
    localparam int RECIP_W  = RECIP_SH - $clog2(CAL_SAMPLES) + 2;
    localparam int RPROD_W  = MAG_W + RECIP_W;
    localparam int QUO_W    = RPROD_W - RECIP_SH;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(CAL_SAMPLES - 1)) / 64'(CAL_SAMPLES));

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DT = CFG_IDX_W'(1);

    localparam logic [GRAV_W-1:0] GRAVITY_RST = GRAV_W'(16384);
    localparam logic [DT_W-1:0]   DT_RST      = DT_W'(10);

    typedef struct packed {
        logic sum_en;
        logic div_start;
        logic div_step;
        logic div_done;
    } cal_ctl_t;

endpackage

@@ rtl/core/ibci_cal_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibci_cal_lane
// One axis: calibration sum, mean by reciprocal multiplication (magnitude,
// multiply, sign), and offset removal with 16-bit wrap.
// ----------------------------------------------------------------------------
module ibci_cal_lane
    import ibci_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cal_ctl_t                ctl,
    input  logic signed [SMP_W-1:0] raw,
    input  logic [GRAV_W-1:0]       bias_sub,
    output logic signed [SMP_W-1:0] corr
);

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic                    neg_reg, neg_next;
    logic [SMP_W-1:0]        offset_reg, offset_next;
    logic [MAG_W-1:0]        sum_mag;
    logic [RPROD_W-1:0]      prod;
    logic [QUO_W-1:0]        quo_signed;

    assign sum_mag    = MAG_W'(sum_reg[SUM_W-1] ? -sum_reg : sum_reg);
    assign prod       = RPROD_W'(mag_reg) * RPROD_W'(RECIP);
    assign quo_signed = neg_reg ? (~quo_reg + QUO_W'(1)) : quo_reg;

    always_comb begin
        sum_next    = sum_reg;
        mag_next    = mag_reg;
        quo_next    = quo_reg;
        neg_next    = neg_reg;
        offset_next = offset_reg;
        if (ctl.sum_en) begin
            sum_next = sum_reg + SUM_W'(raw) - SUM_W'({1'b0, bias_sub});
        end
        if (ctl.div_start) begin
            mag_next = sum_mag;
            neg_next = sum_reg[SUM_W-1];
        end
        if (ctl.div_step) begin
            quo_next = prod[RPROD_W-1:RECIP_SH];
        end
        if (ctl.div_done) begin
            offset_next = quo_signed[SMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            offset_reg <= '0;
        end else begin
            sum_reg    <= sum_next;
            offset_reg <= offset_next;
        end
        mag_reg <= mag_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    assign corr = raw - $signed(offset_reg);

endmodule

@@ rtl/core/ibci_int_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibci_int_lane
// One axis: registered rate times dt product, then saturating 48-bit
// angle accumulation.
// ----------------------------------------------------------------------------
module ibci_int_lane
    import ibci_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load1,
    input  logic                    load2,
    input  logic signed [SMP_W-1:0] rate,
    input  logic [DT_W-1:0]         dt,
    output logic signed [ANG_W-1:0] angle
);

    localparam logic signed [ANG_W-1:0] ANG_MAX = {1'b0, {(ANG_W-1){1'b1}}};
    localparam logic signed [ANG_W-1:0] ANG_MIN = {1'b1, {(ANG_W-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ANG_W-1:0]  acc_reg, acc_next;
    logic signed [ANG_W:0]    acc_sum;

    assign prod_next = $signed(rate) * $signed({1'b0, dt});
    assign acc_sum   = {acc_reg[ANG_W-1], acc_reg}
                     + {{(ANG_W+1-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb begin
        acc_next = acc_reg;
        if (load2) begin
            if (acc_sum[ANG_W] != acc_sum[ANG_W-1]) begin
                acc_next = acc_sum[ANG_W] ? ANG_MIN : ANG_MAX;
            end else begin
                acc_next = acc_sum[ANG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
        if (load1) begin
            prod_reg <= prod_next;
        end
    end

    assign angle = acc_reg;

endmodule

@@ rtl/core/imu_bias_calibrate_and_integrate_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_bias_calibrate_and_integrate_core
// Six-axis bias calibration followed by offset removal and saturating
// gyro angle integration, one lane per axis.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake              | word
//  s_*       | in  | s_valid / s_ready      | raw accel/gyro xyz, elapsed_ms
//  m_*       | out | m_valid / m_ready      | accel xyz, rate xyz, angle xyz
//  cfg_*     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  After reset, CAL_SAMPLES words are summed (one per cycle) with no output.
//  The means are then formed (magnitude, reciprocal multiply, sign) with
//  s_ready low. After that one word per cycle while m_ready is high,
//  passing the product and accumulate registers.
//  The output register holds while m_ready is low; one more word waits in
//  the product stage. aresetn is synchronous, active low.
// ----------------------------------------------------------------------------
module imu_bias_calibrate_and_integrate_core
    import ibci_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [SMP_W-1:0]     s_raw_accel_x,
    input  logic signed [SMP_W-1:0]     s_raw_accel_y,
    input  logic signed [SMP_W-1:0]     s_raw_accel_z,
    input  logic signed [SMP_W-1:0]     s_raw_gyro_x,
    input  logic signed [SMP_W-1:0]     s_raw_gyro_y,
    input  logic signed [SMP_W-1:0]     s_raw_gyro_z,
    input  logic [DT_W-1:0]             s_elapsed_ms,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SMP_W-1:0]     m_accel_x,
    output logic signed [SMP_W-1:0]     m_accel_y,
    output logic signed [SMP_W-1:0]     m_accel_z,
    output logic signed [SMP_W-1:0]     m_rate_x,
    output logic signed [SMP_W-1:0]     m_rate_y,
    output logic signed [SMP_W-1:0]     m_rate_z,
    output logic signed [ANG_W-1:0]     m_angle_x,
    output logic signed [ANG_W-1:0]     m_angle_y,
    output logic signed [ANG_W-1:0]     m_angle_z,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data
);

    typedef enum logic [1:0] {
        ST_CAL,
        ST_DIV,
        ST_RUN
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cal_cnt_reg, cal_cnt_next;
    logic [DCNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [GRAV_W-1:0]  gravity_reg;
    logic [DT_W-1:0]    dflt_dt_reg;

    logic               s1_valid_reg, s1_valid_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [SMP_W-1:0] s1_corr_reg [6];
    logic signed [SMP_W-1:0] m_corr_reg [6];

    logic               adv2, in_acc, load1, load2;
    cal_ctl_t           ctl;
    logic signed [SMP_W-1:0] raw [6];
    logic signed [SMP_W-1:0] corr [6];
    logic [GRAV_W-1:0]  bias_sub [6];
    logic signed [ANG_W-1:0] angle [3];
    logic [DT_W-1:0]    dt;

    assign raw[0] = s_raw_accel_x;
    assign raw[1] = s_raw_accel_y;
    assign raw[2] = s_raw_accel_z;
    assign raw[3] = s_raw_gyro_x;
    assign raw[4] = s_raw_gyro_y;
    assign raw[5] = s_raw_gyro_z;

    assign bias_sub[0] = '0;
    assign bias_sub[1] = '0;
    assign bias_sub[2] = gravity_reg;
    assign bias_sub[3] = '0;
    assign bias_sub[4] = '0;
    assign bias_sub[5] = '0;

    assign adv2    = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_CAL)
                  || ((state_reg == ST_RUN) && (!s1_valid_reg || adv2));
    assign in_acc  = s_valid && s_ready;
    assign load1   = in_acc && (state_reg == ST_RUN);
    assign load2   = s1_valid_reg && adv2;
    assign dt      = (s_elapsed_ms == '0) ? dflt_dt_reg : s_elapsed_ms;

    assign ctl.sum_en    = in_acc && (state_reg == ST_CAL);
    assign ctl.div_start = (state_reg == ST_DIV) && (div_cnt_reg == '0);
    assign ctl.div_step  = (state_reg == ST_DIV) && (div_cnt_reg == DCNT_W'(1));
    assign ctl.div_done  = (state_reg == ST_DIV) && (div_cnt_reg == DCNT_W'(2));

    always_comb begin
        state_next   = state_reg;
        cal_cnt_next = cal_cnt_reg;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            ST_CAL: begin
                if (in_acc) begin
                    cal_cnt_next = cal_cnt_reg + CNT_W'(1);
                    if (cal_cnt_reg == CNT_W'(CAL_SAMPLES - 1)) begin
                        state_next   = ST_DIV;
                        div_cnt_next = '0;
                    end
                end
            end
            ST_DIV: begin
                div_cnt_next = div_cnt_reg + DCNT_W'(1);
                if (ctl.div_done) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
            end
            default: begin
                state_next = ST_CAL;
            end
        endcase
    end

    assign s1_valid_next = load1 ? 1'b1 : (load2 ? 1'b0 : s1_valid_reg);
    assign m_valid_next  = load2 ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CAL;
            cal_cnt_reg  <= '0;
            div_cnt_reg  <= '0;
            gravity_reg  <= GRAVITY_RST;
            dflt_dt_reg  <= DT_RST;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cal_cnt_reg  <= cal_cnt_next;
            div_cnt_reg  <= div_cnt_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && (cfg_index == REG_GRAVITY)) begin
                gravity_reg <= cfg_data[GRAV_W-1:0];
            end
            if (cfg_valid && (cfg_index == REG_DEFAULT_DT)) begin
                dflt_dt_reg <= cfg_data[DT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 6; i++) begin
            if (load1) begin
                s1_corr_reg[i] <= corr[i];
            end
            if (load2) begin
                m_corr_reg[i] <= s1_corr_reg[i];
            end
        end
    end

    for (genvar g = 0; g < 6; g++) begin : g_cal
        ibci_cal_lane u_cal (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .raw      (raw[g]),
            .bias_sub (bias_sub[g]),
            .corr     (corr[g])
        );
    end

    for (genvar g = 0; g < 3; g++) begin : g_int
        ibci_int_lane u_int (
            .aclk    (aclk),
            .aresetn (aresetn),
            .load1   (load1),
            .load2   (load2),
            .rate    (corr[g + 3]),
            .dt      (dt),
            .angle   (angle[g])
        );
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_accel_x = m_corr_reg[0];
    assign m_accel_y = m_corr_reg[1];
    assign m_accel_z = m_corr_reg[2];
    assign m_rate_x  = m_corr_reg[3];
    assign m_rate_y  = m_corr_reg[4];
    assign m_rate_z  = m_corr_reg[5];
    assign m_angle_x = angle[0];
    assign m_angle_y = angle[1];
    assign m_angle_z = angle[2];

endmodule
